// ===== sv/hsmc_pkg.sv =====
// Package for the hysteresis safety mode controller: level codes, widths, step decision type.
`default_nettype none

package hsmc_pkg;

    localparam int COUNTER_WIDTH_DEF = 32;
    localparam int VAL_W             = 32;
    localparam int TICK_W            = 31;
    localparam int OUT_CNT_W         = 32;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 31;
    localparam int S_TDATA_W         = 96;
    localparam int M_TDATA_W         = 168;

    localparam logic [1:0] LVL_SAFE    = 2'd0;
    localparam logic [1:0] LVL_CAUTION = 2'd1;
    localparam logic [1:0] LVL_STRICT  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ADAPTIVE_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REACTION_ORIGIN = 2'd1;

    localparam logic [TICK_W-1:0] ORIGIN_RESET = 31'd500;

    typedef struct packed {
        logic [1:0] level_next;
        logic       changed;
        logic       up_caution;
        logic       up_strict;
        logic       down_caution;
        logic       down_safe;
    } hsmc_step_t;

endpackage

`default_nettype wire

// ===== sv/hsmc_step.sv =====
// Level decision for one item: hysteresis compares and transition flags.
`default_nettype none

module hsmc_step
    import hsmc_pkg::*;
(
    input  wire logic [1:0]       level,
    input  wire logic             adaptive,
    input  wire logic [VAL_W-1:0] violation,
    input  wire logic [VAL_W-1:0] weight_floor,
    output hsmc_step_t            step
);

    localparam int PROD_W = VAL_W + 6;

    logic [PROD_W-1:0] v_ext;
    logic [PROD_W-1:0] w_ext;
    logic              above_5pct;
    logic              above_10pct;
    logic              below_2pct;
    logic              below_4pct;
    logic [1:0]        lvl_n;

    assign v_ext = {6'd0, violation};
    assign w_ext = {6'd0, weight_floor};

    // exact compares: v*20 > w is v > 5% of w, etc.
    assign above_5pct  = (v_ext * PROD_W'(20)) > w_ext;
    assign above_10pct = (v_ext * PROD_W'(10)) > w_ext;
    assign below_2pct  = (v_ext * PROD_W'(50)) < w_ext;
    assign below_4pct  = (v_ext * PROD_W'(25)) < w_ext;

    always_comb begin
        lvl_n = level;
        if (adaptive) begin
            case (level)
                LVL_SAFE: begin
                    if (above_5pct) lvl_n = LVL_CAUTION;
                end
                LVL_CAUTION: begin
                    if (above_10pct)     lvl_n = LVL_STRICT;
                    else if (below_2pct) lvl_n = LVL_SAFE;
                end
                LVL_STRICT: begin
                    if (below_4pct) lvl_n = LVL_CAUTION;
                end
                default: lvl_n = level;
            endcase
        end
    end

    always_comb begin
        step.level_next   = lvl_n;
        step.changed      = (lvl_n != level);
        step.up_caution   = (level == LVL_SAFE)    && (lvl_n == LVL_CAUTION);
        step.up_strict    = (level == LVL_CAUTION) && (lvl_n == LVL_STRICT);
        step.down_caution = (level == LVL_STRICT)  && (lvl_n == LVL_CAUTION);
        step.down_safe    = (level == LVL_CAUTION) && (lvl_n == LVL_SAFE);
    end

endmodule

`default_nettype wire

// ===== sv/hysteresis_safety_mode_controller.sv =====
// Hysteresis safety mode controller: one safety level update and report per item.
// Each item (violation, weight floor, tick) is taken into an input register; when the result
// register is free, the level decision, counter updates and reaction latch run in one pass
// of logic into the result register, which drives m_tvalid and m_tdata. Throughput is one
// item per cycle while m_tready keeps the result register free, set by the single level
// register that every item reads and, in adaptive mode, writes. The result register can hold
// a finished item while the next one is accepted. The configuration port is always ready and
// is to be written only while no item is in flight.
`default_nettype none

module hysteresis_safety_mode_controller
    import hsmc_pkg::*;
#(
    parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [31:0] violation, [63:32] weight_floor, [94:64] tick_number, [95] zero
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [1:0] safety_level, [2] level_changed, [34:3] up_to_caution_count,
    // [66:35] up_to_strict_count, [98:67] down_to_caution_count,
    // [130:99] down_to_safe_count, [131] reaction_valid, [162:132] reaction_delay,
    // [167:163] zero
    output logic [M_TDATA_W-1:0]       m_tdata,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic                     in_valid_reg;
    logic [VAL_W-1:0]         viol_reg;
    logic [VAL_W-1:0]         weight_reg;
    logic [TICK_W-1:0]        tick_reg;

    logic                     adaptive_reg;
    logic [TICK_W-1:0]        origin_reg;

    logic [1:0]               level_reg;
    logic [COUNTER_WIDTH-1:0] cnt_up_c_reg, cnt_up_c_next;
    logic [COUNTER_WIDTH-1:0] cnt_up_s_reg, cnt_up_s_next;
    logic [COUNTER_WIDTH-1:0] cnt_dn_c_reg, cnt_dn_c_next;
    logic [COUNTER_WIDTH-1:0] cnt_dn_s_reg, cnt_dn_s_next;
    logic                     latched_reg, latched_next;
    logic [TICK_W-1:0]        delay_reg, delay_next;

    logic                     out_valid_reg;
    logic [M_TDATA_W-1:0]     out_data_reg, out_data_next;

    logic                     advance;
    hsmc_step_t               step;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;

    hsmc_step u_step (
        .level        (level_reg),
        .adaptive     (adaptive_reg),
        .violation    (viol_reg),
        .weight_floor (weight_reg),
        .step         (step)
    );

    always_comb begin
        cnt_up_c_next = cnt_up_c_reg;
        cnt_up_s_next = cnt_up_s_reg;
        cnt_dn_c_next = cnt_dn_c_reg;
        cnt_dn_s_next = cnt_dn_s_reg;
        if (step.up_caution && (cnt_up_c_reg != '1)) cnt_up_c_next = cnt_up_c_reg + 1'b1;
        if (step.up_strict && (cnt_up_s_reg != '1))  cnt_up_s_next = cnt_up_s_reg + 1'b1;
        if (step.down_caution && (cnt_dn_c_reg != '1)) cnt_dn_c_next = cnt_dn_c_reg + 1'b1;
        if (step.down_safe && (cnt_dn_s_reg != '1))  cnt_dn_s_next = cnt_dn_s_reg + 1'b1;

        latched_next = latched_reg;
        delay_next   = delay_reg;
        if (!latched_reg && step.changed && (tick_reg >= origin_reg)) begin
            latched_next = 1'b1;
            delay_next   = tick_reg - origin_reg;
        end

        out_data_next = {
            5'd0,
            delay_next,
            latched_next,
            OUT_CNT_W'(cnt_dn_s_next),
            OUT_CNT_W'(cnt_dn_c_next),
            OUT_CNT_W'(cnt_up_s_next),
            OUT_CNT_W'(cnt_up_c_next),
            step.changed,
            step.level_next
        };
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            adaptive_reg  <= 1'b1;
            origin_reg    <= ORIGIN_RESET;
            level_reg     <= LVL_SAFE;
            cnt_up_c_reg  <= '0;
            cnt_up_s_reg  <= '0;
            cnt_dn_c_reg  <= '0;
            cnt_dn_s_reg  <= '0;
            latched_reg   <= 1'b0;
            delay_reg     <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid) begin
                case (cfg_index)
                    REG_ADAPTIVE_ENABLE: adaptive_reg <= cfg_data[0];
                    REG_REACTION_ORIGIN: origin_reg   <= cfg_data;
                    default: ;
                endcase
            end

            // frozen mode leaves the level, counters, reaction latch and delay as they were
            if (advance && adaptive_reg) begin
                level_reg    <= step.level_next;
                cnt_up_c_reg <= cnt_up_c_next;
                cnt_up_s_reg <= cnt_up_s_next;
                cnt_dn_c_reg <= cnt_dn_c_next;
                cnt_dn_s_reg <= cnt_dn_s_next;
                latched_reg  <= latched_next;
                delay_reg    <= delay_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            viol_reg   <= s_tdata[31:0];
            weight_reg <= s_tdata[63:32];
            tick_reg   <= s_tdata[94:64];
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef SYNTH
    a_level_only_on_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(level_reg))
        else $error("level moved without an item");

    a_frozen_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !adaptive_reg) |=> $stable(level_reg) && $stable(cnt_up_c_reg)
            && $stable(latched_reg))
        else $error("state moved while adaptive mode off");

    a_latch_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        latched_reg |=> latched_reg && $stable(delay_reg))
        else $error("reaction latch lost or delay changed");

    a_changed_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_data_reg[2] == (level_reg != $past(level_reg)))
        else $error("level_changed disagrees with level update");
`endif

endmodule

`default_nettype wire
